// ----- src/text_position_line_column_tracker_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Text position tracker assertion macros
// Shared property forms for the checkers of the text position tracker.
// ----------------------------------------------------------------------------
`ifndef TEXT_POSITION_LINE_COLUMN_TRACKER_UNIT_DEFINES_SVH
`define TEXT_POSITION_LINE_COLUMN_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define TPLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tplc check failed: same-cycle property");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define TPLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tplc check failed: next-cycle property");

`endif

// ----- src/tplc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text position tracker package
// Field widths, word types, status codes and character constants.
// ----------------------------------------------------------------------------
package tplc_pkg;

  localparam int INDEX_BITS_DEF = 24;

  localparam int TOTAL_W = 24;
  localparam int CP_W    = 16;
  localparam int BLEN_W  = 3;
  localparam int LC_W    = 25;
  localparam int POS_W   = 24;

  typedef logic [TOTAL_W-1:0] tplc_total_t;
  typedef logic [LC_W-1:0]    tplc_lc_t;
  typedef logic [POS_W-1:0]   tplc_pos_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_AT_END  = 2'd1,
    ST_OVERRUN = 2'd2
  } tplc_status_t;

  typedef enum logic {
    ACT_PEEK    = 1'b0,
    ACT_ADVANCE = 1'b1
  } tplc_action_t;

  typedef struct packed {
    tplc_action_t      action;
    logic [CP_W-1:0]   code_point;
    logic [BLEN_W-1:0] byte_length;
  } tplc_in_t;

  typedef struct packed {
    tplc_status_t status;
    logic         is_space;
    logic         is_letter;
    logic         is_digit;
    tplc_lc_t     line;
    tplc_lc_t     column;
    tplc_pos_t    char_index;
    tplc_pos_t    byte_index;
    logic         end_reached;
  } tplc_out_t;

  // Line break characters.
  localparam logic [CP_W-1:0] CH_CR = 16'h000d;
  localparam logic [CP_W-1:0] CH_LF = 16'h000a;

  // Class ranges.
  localparam logic [CP_W-1:0] CH_TAB      = 16'h0009;
  localparam logic [CP_W-1:0] CH_SPACE    = 16'h0020;
  localparam logic [CP_W-1:0] CH_DIGIT_LO = 16'h0030;
  localparam logic [CP_W-1:0] CH_DIGIT_HI = 16'h0039;
  localparam logic [CP_W-1:0] CH_UPPER_LO = 16'h0041;
  localparam logic [CP_W-1:0] CH_UPPER_HI = 16'h005a;
  localparam logic [CP_W-1:0] CH_LOWER_LO = 16'h0061;
  localparam logic [CP_W-1:0] CH_LOWER_HI = 16'h007a;
  localparam logic [CP_W-1:0] CH_LAT1A_LO = 16'h00c0;
  localparam logic [CP_W-1:0] CH_LAT1A_HI = 16'h00d6;
  localparam logic [CP_W-1:0] CH_LAT1B_LO = 16'h00d8;
  localparam logic [CP_W-1:0] CH_LAT1B_HI = 16'h00f6;
  localparam logic [CP_W-1:0] CH_LAT1C_LO = 16'h00f8;

  // The CR pair wins when 100 * cr >= 301 * lf, i.e. cr/lf is at least 3.01.
  localparam int CR_WEIGHT = 100;
  localparam int LF_WEIGHT = 301;

endpackage

// ----- src/tplc_stream_if.sv -----
// ----------------------------------------------------------------------------
// Text position tracker stream interface
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface tplc_stream_if #(
  parameter type PAYLOAD_T = logic
) ();

  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- src/text_position_line_column_tracker_unit.sv -----
// A word taken at the input is registered in the first stage, then in the
// result register. Throughput: one word per cycle unless the output stalls; the
// position update for a word and the line/column estimate (two constant
// multiplies and a compare) each take one register stage. Synchronous
// active-low reset clears the position, the buffer length and both stage valids.
// ----------------------------------------------------------------------------
// Text position line/column tracker
// Tracks byte and character position, CR/LF counts and columns, and
// reports an estimated line and column with character class flags.
// ----------------------------------------------------------------------------
module text_position_line_column_tracker_unit #(
  parameter int INDEX_BITS = tplc_pkg::INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  tplc_pkg::tplc_total_t    cfg_wr_data,
  tplc_stream_if.sink              in_if,
  tplc_stream_if.source            out_if
);

  localparam int IB1 = INDEX_BITS + 1;
  localparam int PW  = INDEX_BITS + 9;
  localparam logic [INDEX_BITS-1:0] IDX_ZERO = '0;
  localparam logic [INDEX_BITS-1:0] IDX_ONE  = {{(INDEX_BITS-1){1'b0}}, 1'b1};

  // Position state.
  logic [INDEX_BITS-1:0] total_r;
  logic [INDEX_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [INDEX_BITS-1:0] char_cnt_r, char_cnt_nxt;
  logic [INDEX_BITS-1:0] cr_tot_r, cr_tot_nxt;
  logic [INDEX_BITS-1:0] lf_tot_r, lf_tot_nxt;
  logic [INDEX_BITS-1:0] since_cr_r, since_cr_nxt;
  logic [INDEX_BITS-1:0] since_lf_r, since_lf_nxt;
  logic                  at_end_r, at_end_nxt;

  // First stage: status and class flags of the word just taken.
  logic                   s1_v_r, s1_v_nxt;
  tplc_pkg::tplc_status_t s1_status_r, s1_status_nxt;
  logic                   s1_space_r, s1_space_nxt;
  logic                   s1_letter_r, s1_letter_nxt;
  logic                   s1_digit_r, s1_digit_nxt;

  // Result register.
  logic                   out_v_r, out_v_nxt;
  tplc_pkg::tplc_out_t    out_data_r, out_data_nxt;

  logic out_can, s1_ready, in_acc, s1_move;

  logic [IB1-1:0]          next_pos;
  logic                    overrun;
  logic                    classify;
  logic [tplc_pkg::CP_W-1:0] cp;

  logic [PW-1:0]  cr_scaled, lf_scaled;
  logic           use_cr;
  logic [IB1-1:0] line_sum, col_sum;

  assign out_can  = !out_v_r || out_if.ready;
  assign s1_ready = !s1_v_r || out_can;
  assign in_acc   = in_if.valid && s1_ready;
  assign s1_move  = s1_v_r && out_can;

  assign in_if.ready  = s1_ready;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_data_r;

  assign cp       = in_if.data.code_point;
  assign next_pos = {1'b0, byte_pos_r} + IB1'(in_if.data.byte_length);
  assign overrun  = next_pos > {1'b0, total_r};

  // Position update for the word being taken.
  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    char_cnt_nxt  = char_cnt_r;
    cr_tot_nxt    = cr_tot_r;
    lf_tot_nxt    = lf_tot_r;
    since_cr_nxt  = since_cr_r;
    since_lf_nxt  = since_lf_r;
    at_end_nxt    = at_end_r;
    s1_status_nxt = tplc_pkg::ST_OK;
    classify      = 1'b0;
    if (at_end_r) begin
      s1_status_nxt = tplc_pkg::ST_AT_END;
    end else if (byte_pos_r >= total_r) begin
      at_end_nxt = 1'b1;
    end else if (in_if.data.action == tplc_pkg::ACT_PEEK) begin
      if (overrun) begin
        s1_status_nxt = tplc_pkg::ST_OVERRUN;
      end else begin
        classify = 1'b1;
      end
    end else begin
      if (next_pos >= {1'b0, total_r}) begin
        at_end_nxt = 1'b1;
      end
      if (overrun) begin
        s1_status_nxt = tplc_pkg::ST_OVERRUN;
      end else begin
        classify     = 1'b1;
        byte_pos_nxt = next_pos[INDEX_BITS-1:0];
        char_cnt_nxt = char_cnt_r + IDX_ONE;
        if (cp == tplc_pkg::CH_CR) begin
          cr_tot_nxt   = cr_tot_r + IDX_ONE;
          since_cr_nxt = IDX_ZERO;
          since_lf_nxt = since_lf_r + IDX_ONE;
        end else if (cp == tplc_pkg::CH_LF) begin
          lf_tot_nxt   = lf_tot_r + IDX_ONE;
          since_lf_nxt = IDX_ZERO;
          since_cr_nxt = since_cr_r + IDX_ONE;
        end else begin
          since_cr_nxt = since_cr_r + IDX_ONE;
          since_lf_nxt = since_lf_r + IDX_ONE;
        end
      end
    end

    s1_space_nxt  = classify &&
                    (((cp >= tplc_pkg::CH_TAB) && (cp <= tplc_pkg::CH_CR)) ||
                     (cp == tplc_pkg::CH_SPACE));
    s1_letter_nxt = classify &&
                    (((cp >= tplc_pkg::CH_UPPER_LO) && (cp <= tplc_pkg::CH_UPPER_HI)) ||
                     ((cp >= tplc_pkg::CH_LOWER_LO) && (cp <= tplc_pkg::CH_LOWER_HI)) ||
                     ((cp >= tplc_pkg::CH_LAT1A_LO) && (cp <= tplc_pkg::CH_LAT1A_HI)) ||
                     ((cp >= tplc_pkg::CH_LAT1B_LO) && (cp <= tplc_pkg::CH_LAT1B_HI)) ||
                     (cp >= tplc_pkg::CH_LAT1C_LO));
    s1_digit_nxt  = classify &&
                    ((cp >= tplc_pkg::CH_DIGIT_LO) && (cp <= tplc_pkg::CH_DIGIT_HI));
  end

  // The estimate reads the live state: while a word sits in the first stage
  // no later word can have been taken, so the state is still the one it left.
  assign cr_scaled = PW'(cr_tot_r) * PW'(tplc_pkg::CR_WEIGHT);
  assign lf_scaled = PW'(lf_tot_r) * PW'(tplc_pkg::LF_WEIGHT);

  always_comb begin
    if ((cr_tot_r == lf_tot_r) || (cr_tot_r == IDX_ZERO)) begin
      use_cr = 1'b0;
    end else if (lf_tot_r == IDX_ZERO) begin
      use_cr = 1'b1;
    end else begin
      use_cr = cr_scaled >= lf_scaled;
    end
  end

  assign line_sum = use_cr ? ({1'b0, cr_tot_r} + IB1'(1)) : ({1'b0, lf_tot_r} + IB1'(1));
  assign col_sum  = use_cr ? ({1'b0, since_cr_r} + IB1'(1))
                           : ({1'b0, since_lf_r} + IB1'(1));

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_acc;
    end
    out_v_nxt = out_v_r;
    if (out_can) begin
      out_v_nxt = s1_v_r;
    end
    out_data_nxt.status      = s1_status_r;
    out_data_nxt.is_space    = s1_space_r;
    out_data_nxt.is_letter   = s1_letter_r;
    out_data_nxt.is_digit    = s1_digit_r;
    out_data_nxt.line        = tplc_pkg::tplc_lc_t'(line_sum);
    out_data_nxt.column      = tplc_pkg::tplc_lc_t'(col_sum);
    out_data_nxt.char_index  = tplc_pkg::tplc_pos_t'(char_cnt_r);
    out_data_nxt.byte_index  = tplc_pkg::tplc_pos_t'(byte_pos_r);
    out_data_nxt.end_reached = at_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= IDX_ZERO;
      byte_pos_r <= IDX_ZERO;
      char_cnt_r <= IDX_ZERO;
      cr_tot_r   <= IDX_ZERO;
      lf_tot_r   <= IDX_ZERO;
      since_cr_r <= IDX_ZERO;
      since_lf_r <= IDX_ZERO;
      at_end_r   <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_r <= INDEX_BITS'(cfg_wr_data);
      end
      if (in_acc) begin
        byte_pos_r <= byte_pos_nxt;
        char_cnt_r <= char_cnt_nxt;
        cr_tot_r   <= cr_tot_nxt;
        lf_tot_r   <= lf_tot_nxt;
        since_cr_r <= since_cr_nxt;
        since_lf_r <= since_lf_nxt;
        at_end_r   <= at_end_nxt;
      end
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= s1_status_nxt;
      s1_space_r  <= s1_space_nxt;
      s1_letter_r <= s1_letter_nxt;
      s1_digit_r  <= s1_digit_nxt;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- src/tplc_checker.sv -----
// ----------------------------------------------------------------------------
// Text position tracker checker
// Watches the result channel of the tracker and checks its words over time.
// ----------------------------------------------------------------------------
`include "text_position_line_column_tracker_unit_defines.svh"

module tplc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tplc_pkg::tplc_out_t out_data
);

  logic       no_class;
  logic [2:0] class_bits;
  logic       show_at_end;
  logic       show_overrun;
  logic       end_taken;

  assign class_bits   = {out_data.is_space, out_data.is_letter, out_data.is_digit};
  assign no_class     = (class_bits == 3'b000);
  assign show_at_end  = out_valid && (out_data.status == tplc_pkg::ST_AT_END);
  assign show_overrun = out_valid && (out_data.status == tplc_pkg::ST_OVERRUN);
  assign end_taken    = out_valid && out_ready && out_data.end_reached;

  // A word that reports end carries the end flag and no class; an overrun
  // carries no class, but a peek that overruns leaves the end flag clear.
  `TPLC_ASSERT_SAME(a_at_end_flags, clk, rst_n, show_at_end, out_data.end_reached && no_class)
  `TPLC_ASSERT_SAME(a_overrun_flags, clk, rst_n, show_overrun, no_class)

  // The class flags exclude one another.
  `TPLC_ASSERT_SAME(a_class_excl, clk, rst_n, out_valid, $onehot0(class_bits))

  // Once a word shows the end flag, the next word taken shows it too.
  `TPLC_ASSERT_NEXT(a_end_sticky, clk, rst_n, end_taken, !out_valid || out_data.end_reached)

  // A stalled word holds.
  `TPLC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind text_position_line_column_tracker_unit tplc_checker u_tplc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
